### rtl/mrc_pkg.sv
// Shared types and encodings for the mini RISC step core.
package mrc_pkg;

  // Request operations
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_EXEC = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Instruction encodings
  localparam logic [5:0] OPC_RTYPE = 6'd48;
  localparam logic [5:0] FN_ADD    = 6'd10;
  localparam logic [5:0] FN_OR     = 6'd48;
  localparam logic [5:0] FN_SLT    = 6'd15;
  localparam logic [5:0] FN_XOR    = 6'd20;
  localparam logic [5:0] OPC_SUBI  = 6'd28;
  localparam logic [5:0] OPC_LW    = 6'd6;
  localparam logic [5:0] OPC_SW    = 6'd2;
  localparam logic [5:0] OPC_BGE   = 6'd39;
  localparam logic [5:0] OPC_J     = 6'd36;
  localparam logic [5:0] OPC_JAL   = 6'd34;

  localparam int          NUM_REGS = 32;
  localparam logic [4:0]  LINK_REG = 5'd31;

  typedef struct packed {
    logic [1:0]  op;
    logic [6:0]  load_address;
    logic [31:0] load_word;
    logic [4:0]  read_index;
  } mrc_in_t;

  typedef struct packed {
    logic [6:0]         pc_after;
    logic               reg_written;
    logic [4:0]         reg_dest;
    logic signed [31:0] reg_value;
    logic               mem_written;
    logic [9:0]         mem_word_index;
    logic signed [31:0] mem_value;
    logic               branch_taken;
    logic               unknown_instr;
    logic signed [31:0] read_value;
  } mrc_out_t;

  // Classified request as held in the queue
  typedef struct packed {
    logic        is_load;
    logic        is_exec;
    logic        is_read;
    logic [6:0]  load_address;
    logic [31:0] load_word;
    logic [4:0]  read_index;
  } mrc_req_t;

endpackage

### rtl/mrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mrc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/mrc_mod.sv
// Reduces a 32-bit unsigned value modulo a constant depth.
module mrc_mod #(
  parameter int DIV = 128
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [31:0]            value,
  output logic                   done,
  output logic [$clog2(DIV)-1:0] result
);

  localparam int RW = $clog2(DIV);

  generate
    if ((1 << RW) == DIV) begin : g_pow2
      // Power of two: the remainder is the low bits
      logic          done_r;
      logic [RW-1:0] res_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
        if (start) begin
          res_r <= value[RW-1:0];
        end
      end

      assign done   = done_r;
      assign result = res_r;
    end else begin : g_recip
      // Reciprocal multiply: quotient = (value * RCP) >> SH, exact for 32-bit values;
      // remainder = value - quotient * DIV. Value, product and q*DIV are registered.
      localparam int          SH  = 32 + RW;
      localparam logic [63:0] RCP = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);
      logic          ph1_r;
      logic          ph2_r;
      logic          done_r;
      logic [31:0]   val_r;
      logic [64:0]   prod_r;
      logic [31:0]   qd_r;
      logic [31:0]   quo;
      logic [31:0]   rem;

      assign quo = 32'(prod_r >> SH);
      assign rem = val_r - qd_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          ph1_r  <= 1'b0;
          ph2_r  <= 1'b0;
          done_r <= 1'b0;
        end else begin
          ph1_r  <= start;
          ph2_r  <= ph1_r;
          done_r <= ph2_r;
        end
        if (start) begin
          val_r <= value;
        end
        if (ph1_r) begin
          prod_r <= 65'(val_r) * 65'(RCP[32:0]);
        end
        if (ph2_r) begin
          qd_r <= quo * 32'(DIV);
        end
      end

      assign done   = done_r;
      assign result = rem[RW-1:0];
    end
  endgenerate

endmodule

### rtl/mrc_front.sv
// Front end: accepts requests, classifies them and queues them.
module mrc_front
  import mrc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  mrc_in_t  in_data,
  input  logic     clearing,
  output logic     q_valid,
  output mrc_req_t q_head,
  input  logic     q_pop
);

  mrc_req_t   fifo_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       push;
  mrc_req_t   cls;

  // Classify the operation
  always_comb begin
    cls              = '0;
    cls.is_load      = (in_data.op == OP_LOAD);
    cls.is_exec      = (in_data.op == OP_EXEC);
    cls.is_read      = (in_data.op == OP_READ);
    cls.load_address = in_data.load_address;
    cls.load_word    = in_data.load_word;
    cls.read_index   = in_data.read_index;
  end

  assign in_stall = (cnt_r == 2'd2) || clearing;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_head   = fifo_r[rptr_r];

  // Two-entry queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= !wptr_r;
      end
      if (q_pop) begin
        rptr_r <= !rptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
    if (push) begin
      fifo_r[wptr_r] <= cls;
    end
  end

endmodule

### rtl/mrc_back.sv
// Back end: memory clear, fetch, decode, execute and result register.
module mrc_back
  import mrc_pkg::*;
#(
  parameter int INSTR_DEPTH = 128,
  parameter int DATA_DEPTH  = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  output logic     clearing,
  input  logic     q_valid,
  input  mrc_req_t q_head,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_stall,
  output mrc_out_t out_data
);

  localparam int IW    = $clog2(INSTR_DEPTH);
  localparam int DW    = $clog2(DATA_DEPTH);
  localparam int CLR_A = (INSTR_DEPTH > DATA_DEPTH) ? INSTR_DEPTH : DATA_DEPTH;
  localparam int CLR_N = (CLR_A > NUM_REGS) ? CLR_A : NUM_REGS;
  localparam int CW    = $clog2(CLR_N + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_EXE   = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;
  localparam logic [2:0] S_MEM   = 3'd5;
  localparam logic [2:0] S_RD    = 3'd6;
  localparam logic [2:0] S_LD    = 3'd7;

  localparam logic [1:0] K_NONE = 2'd0;
  localparam logic [1:0] K_LW   = 2'd1;
  localparam logic [1:0] K_SW   = 2'd2;
  localparam logic [1:0] K_BR   = 2'd3;

  logic [2:0]    st_r;
  mrc_req_t      cur_r;
  logic [31:0]   instr_r;
  logic [IW-1:0] pc_r;
  logic [1:0]    kind_r;
  logic [4:0]    dst_r;
  logic [31:0]   b_r;
  logic          clr_r;
  logic [CW-1:0] clr_cnt_r;
  logic          out_valid_r;
  mrc_out_t      out_r;

  logic [31:0]   im_rdata, dm_rdata, rfa_rdata, rfb_rdata;
  logic          im_we, dm_we, rf_we;
  logic [IW-1:0] im_waddr;
  logic [DW-1:0] dm_waddr;
  logic [4:0]    rf_waddr, rfa_raddr;
  logic [31:0]   im_wdata, dm_wdata, rf_wdata;
  logic          im_start, dm_start, im_done, dm_done;
  logic [31:0]   im_val;
  logic [IW-1:0] im_res;
  logic [DW-1:0] dm_res;

  // Decode and ALU
  logic [5:0]    opc, fn;
  logic [4:0]    rs, rt, rd;
  logic [31:0]   imm32, tgt32, a, b, sum, idx32, diff, pc1_32;
  logic [IW-1:0] pc1;
  logic          ex_wr, ex_unk;
  logic [4:0]    ex_dst;
  logic [31:0]   ex_val, ex_modv;
  logic [1:0]    ex_kind;

  assign opc    = instr_r[31:26];
  assign fn     = instr_r[5:0];
  assign rs     = instr_r[25:21];
  assign rt     = instr_r[20:16];
  assign rd     = instr_r[15:11];
  assign imm32  = {{16{instr_r[15]}}, instr_r[15:0]};
  assign tgt32  = {{6{instr_r[25]}}, instr_r[25:0]};
  assign a      = rfa_rdata;
  assign b      = rfb_rdata;
  assign sum    = a + imm32;
  assign idx32  = {{2{sum[31]}}, sum[31:2]};
  assign diff   = a - b;
  assign pc1    = (pc_r == IW'(INSTR_DEPTH - 1)) ? '0 : pc_r + IW'(1);
  assign pc1_32 = 32'(pc1);

  always_comb begin
    ex_wr   = 1'b0;
    ex_unk  = 1'b0;
    ex_dst  = 5'd0;
    ex_val  = 32'd0;
    ex_kind = K_NONE;
    ex_modv = idx32;
    unique case (opc)
      OPC_RTYPE: begin
        ex_wr  = 1'b1;
        ex_dst = rd;
        unique case (fn)
          FN_ADD: ex_val = a + b;
          FN_OR:  ex_val = a | b;
          FN_SLT: ex_val = {31'd0, ($signed(a) < $signed(b))};
          FN_XOR: ex_val = a ^ b;
          default: begin
            ex_wr  = 1'b0;
            ex_dst = 5'd0;
            ex_unk = 1'b1;
          end
        endcase
      end
      OPC_SUBI: begin
        ex_wr  = 1'b1;
        ex_dst = rt;
        ex_val = a - imm32;
      end
      OPC_LW: begin
        ex_dst  = rt;
        ex_kind = K_LW;
      end
      OPC_SW: ex_kind = K_SW;
      OPC_BGE: begin
        if (!diff[31]) begin
          ex_kind = K_BR;
          ex_modv = pc1_32 + imm32;
        end
      end
      OPC_J: begin
        ex_kind = K_BR;
        ex_modv = tgt32;
      end
      OPC_JAL: begin
        ex_wr   = 1'b1;
        ex_dst  = LINK_REG;
        ex_val  = pc1_32;
        ex_kind = K_BR;
        ex_modv = tgt32;
      end
      default: ex_unk = 1'b1;
    endcase
  end

  assign q_pop = (st_r == S_IDLE) && q_valid && !out_valid_r && !clr_r;

  // Modulo units for instruction and data indexes
  assign im_start = (q_pop && q_head.is_load) || (st_r == S_EXE && ex_kind == K_BR);
  assign im_val   = (st_r == S_EXE) ? ex_modv : 32'(q_head.load_address);
  assign dm_start = (st_r == S_EXE) && (ex_kind == K_LW || ex_kind == K_SW);

  mrc_mod #(.DIV(INSTR_DEPTH)) u_im_mod (
    .clk(clk), .rst_n(rst_n), .start(im_start), .value(im_val),
    .done(im_done), .result(im_res)
  );

  mrc_mod #(.DIV(DATA_DEPTH)) u_dm_mod (
    .clk(clk), .rst_n(rst_n), .start(dm_start), .value(ex_modv),
    .done(dm_done), .result(dm_res)
  );

  // Memory write ports, shared with the clearing pass
  assign im_we    = clr_r ? (clr_cnt_r < CW'(INSTR_DEPTH)) : (st_r == S_LD && im_done);
  assign im_waddr = clr_r ? clr_cnt_r[IW-1:0] : im_res;
  assign im_wdata = clr_r ? 32'd0 : cur_r.load_word;

  assign dm_we    = clr_r ? (clr_cnt_r < CW'(DATA_DEPTH))
                          : (st_r == S_MOD && kind_r == K_SW && dm_done);
  assign dm_waddr = clr_r ? clr_cnt_r[DW-1:0] : dm_res;
  assign dm_wdata = clr_r ? 32'd0 : b_r;

  assign rf_we    = clr_r ? (clr_cnt_r < CW'(NUM_REGS))
                          : ((st_r == S_EXE && ex_wr) || st_r == S_MEM);
  assign rf_waddr = clr_r ? clr_cnt_r[4:0] : ((st_r == S_MEM) ? dst_r : ex_dst);
  assign rf_wdata = clr_r ? 32'd0 : ((st_r == S_MEM) ? dm_rdata : ex_val);

  assign rfa_raddr = (st_r == S_IDLE) ? q_head.read_index : rs;

  mrc_ram #(.WIDTH(32), .DEPTH(INSTR_DEPTH)) u_imem (
    .clk(clk), .we(im_we), .waddr(im_waddr), .wdata(im_wdata),
    .raddr(pc_r), .rdata(im_rdata)
  );

  mrc_ram #(.WIDTH(32), .DEPTH(DATA_DEPTH)) u_dmem (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .raddr(dm_res), .rdata(dm_rdata)
  );

  // Two copies of the register file give two read ports
  mrc_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rfa_raddr), .rdata(rfa_rdata)
  );

  mrc_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
    .raddr(rt), .rdata(rfb_rdata)
  );

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      pc_r        <= '0;
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + CW'(1);
        if (clr_cnt_r == CW'(CLR_N - 1)) begin
          clr_r <= 1'b0;
        end
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (st_r)
        S_IDLE: begin
          if (q_pop) begin
            priority if (q_head.is_load) begin
              st_r <= S_LD;
            end else if (q_head.is_exec) begin
              st_r <= S_FETCH;
            end else if (q_head.is_read) begin
              st_r <= S_RD;
            end else begin
              out_valid_r <= 1'b1;
            end
          end
        end
        S_FETCH: st_r <= S_DEC;
        S_DEC:   st_r <= S_EXE;
        S_EXE: begin
          pc_r <= pc1;
          if (ex_kind == K_NONE) begin
            st_r        <= S_IDLE;
            out_valid_r <= 1'b1;
          end else begin
            st_r <= S_MOD;
          end
        end
        S_MOD: begin
          if (kind_r == K_BR) begin
            if (im_done) begin
              pc_r        <= im_res;
              st_r        <= S_IDLE;
              out_valid_r <= 1'b1;
            end
          end else if (dm_done) begin
            if (kind_r == K_LW) begin
              st_r <= S_MEM;
            end else begin
              st_r        <= S_IDLE;
              out_valid_r <= 1'b1;
            end
          end
        end
        S_MEM, S_RD: begin
          st_r        <= S_IDLE;
          out_valid_r <= 1'b1;
        end
        S_LD: begin
          if (im_done) begin
            st_r        <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end

    // Payload
    unique case (st_r)
      S_IDLE: begin
        if (q_pop) begin
          cur_r          <= q_head;
          out_r          <= '0;
          out_r.pc_after <= 7'(pc_r);
        end
      end
      S_FETCH: instr_r <= im_rdata;
      S_EXE: begin
        kind_r               <= ex_kind;
        dst_r                <= ex_dst;
        b_r                  <= b;
        out_r.pc_after       <= 7'(pc1);
        out_r.reg_written    <= ex_wr;
        out_r.reg_dest       <= ex_dst & {5{ex_wr}};
        out_r.reg_value      <= ex_val;
        out_r.unknown_instr  <= ex_unk;
      end
      S_MOD: begin
        if (kind_r == K_BR) begin
          out_r.pc_after     <= 7'(im_res);
          out_r.branch_taken <= 1'b1;
        end else begin
          out_r.mem_word_index <= 10'(dm_res);
          if (kind_r == K_SW) begin
            out_r.mem_written <= 1'b1;
            out_r.mem_value   <= b_r;
          end
        end
      end
      S_MEM: begin
        out_r.reg_written <= 1'b1;
        out_r.reg_dest    <= dst_r;
        out_r.reg_value   <= dm_rdata;
      end
      S_RD: out_r.read_value <= rfa_rdata;
      default: ;
    endcase
  end

  assign clearing  = clr_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### rtl/mini_risc_core_step.sv
// Top level of the mini RISC step core: front queue plus execution back end.
//
// Usage: one request on the in_ channel performs one operation: load an
// instruction word (op 0), execute the instruction at pc (op 1) or read a
// register (op 2). Each request yields exactly one result on the out_
// channel, in order. Both channels use valid/stall; a request moves when
// valid is high and stall is low.
// Steps: op 3 returns at dequeue, a read passes S_RD, a load waits for the
// index reduction; an instruction is fetched, decoded and executed, and a
// taken branch, sw or lw waits for the reduction, lw then reading data memory.
// Power-of-two depths reduce by low bits, others by a reciprocal multiply.
// One request is executed at a time; the instruction, data and register
// RAMs with registered reads set the fetch, decode, execute sequence.
// A two-entry queue takes new requests while the back end works, and the
// result register holds a finished result while out_stall is high; the
// back end waits for the result to be taken before starting the next one.
// Reset: pc goes to 0 and a clearing pass zeroes all memories, the register
// file included; in_stall is high meanwhile.
module mini_risc_core_step
  import mrc_pkg::*;
#(
  parameter int INSTR_DEPTH = 128,
  parameter int DATA_DEPTH  = 1024
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  mrc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output mrc_out_t out_data
);

  logic     clearing;
  logic     q_valid;
  logic     q_pop;
  mrc_req_t q_head;

  mrc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .clearing(clearing), .q_valid(q_valid),
    .q_head(q_head), .q_pop(q_pop)
  );

  mrc_back #(.INSTR_DEPTH(INSTR_DEPTH), .DATA_DEPTH(DATA_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .clearing(clearing), .q_valid(q_valid),
    .q_head(q_head), .q_pop(q_pop), .out_valid(out_valid),
    .out_stall(out_stall), .out_data(out_data)
  );

  // No result appears while memories are being cleared
  a_no_out_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_valid)
    else $error("result during clearing pass");

  // A step never writes both a register and data memory
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.reg_written && out_data.mem_written))
    else $error("register and memory write in one step");

  // A dequeue only happens when the result register is free
  a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (!out_valid && q_valid))
    else $error("dequeue with result pending");

  // Reported pc stays inside instruction memory
  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((INSTR_DEPTH > 128) || (32'(out_data.pc_after) < INSTR_DEPTH)))
    else $error("pc out of range");

endmodule

### dv/tb_mini_risc_core_step.sv
// Testbench for mini_risc_core_step: predicts each request's result and checks it in order.
`timescale 1ns / 1ps
module tb_mini_risc_core_step;
  import mrc_pkg::*;

  localparam int IDEPTH = 128;
  localparam int DDEPTH = 1024;
  localparam logic [1:0] OP_NONE = 2'd3;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  mrc_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  mrc_out_t out_data;

  mini_risc_core_step u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Shadow of the core state
  logic [31:0] shadow_regs [32];
  logic [31:0] shadow_imem [IDEPTH];
  logic [31:0] shadow_dmem [DDEPTH];
  logic [6:0]  shadow_pc;

  mrc_in_t  pending_reqs[$];
  mrc_out_t expected_results[$];
  int       error_count = 0;
  bit       stim_done = 0;
  bit       no_idle = 0;
  bit       hold_send = 0;

  function automatic logic [9:0] data_index(logic [31:0] addr);
    return addr[11:2];
  endfunction

  // Compute the result of one accepted request and update the shadow state
  function automatic mrc_out_t core_result(mrc_in_t req);
    mrc_out_t r;
    logic [31:0] w, a, b, imm, tgt, v;
    logic [5:0] opc, fn;
    logic [4:0] rs, rt, rd;
    logic [6:0] pc1;
    logic [9:0] idx;
    r = '0;
    if (req.op == OP_LOAD) begin
      shadow_imem[req.load_address] = req.load_word;
    end else if (req.op == OP_READ) begin
      r.read_value = shadow_regs[req.read_index];
    end else if (req.op == OP_EXEC) begin
      w = shadow_imem[shadow_pc];
      pc1 = shadow_pc + 7'd1;
      opc = w[31:26]; fn = w[5:0];
      rs = w[25:21]; rt = w[20:16]; rd = w[15:11];
      imm = {{16{w[15]}}, w[15:0]};
      tgt = {{6{w[25]}}, w[25:0]};
      a = shadow_regs[rs]; b = shadow_regs[rt];
      shadow_pc = pc1;
      case (opc)
        OPC_RTYPE: begin
          case (fn)
            FN_ADD: v = a + b;
            FN_OR:  v = a | b;
            FN_SLT: v = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            FN_XOR: v = a ^ b;
            default: v = 'x;
          endcase
          if (fn inside {FN_ADD, FN_OR, FN_SLT, FN_XOR}) begin
            r.reg_written = 1; r.reg_dest = rd; r.reg_value = v;
          end else begin
            r.unknown_instr = 1;
          end
        end
        OPC_SUBI: begin
          r.reg_written = 1; r.reg_dest = rt; r.reg_value = a - imm;
        end
        OPC_LW: begin
          idx = data_index(a + imm);
          r.reg_written = 1; r.reg_dest = rt; r.reg_value = shadow_dmem[idx];
          r.mem_word_index = idx;
        end
        OPC_SW: begin
          idx = data_index(a + imm);
          shadow_dmem[idx] = b;
          r.mem_written = 1; r.mem_word_index = idx; r.mem_value = b;
        end
        OPC_BGE: begin
          v = a - b;
          if (!v[31]) begin
            shadow_pc = pc1 + imm[6:0];
            r.branch_taken = 1;
          end
        end
        OPC_J: begin
          shadow_pc = tgt[6:0]; r.branch_taken = 1;
        end
        OPC_JAL: begin
          r.reg_written = 1; r.reg_dest = LINK_REG; r.reg_value = {25'd0, pc1};
          shadow_pc = tgt[6:0]; r.branch_taken = 1;
        end
        default: r.unknown_instr = 1;
      endcase
      if (r.reg_written) shadow_regs[r.reg_dest] = r.reg_value;
    end
    r.pc_after = shadow_pc;
    return r;
  endfunction

  // Clock
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Driver: presents queued requests at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (pending_reqs.size() != 0 && !hold_send &&
          (no_idle || $urandom_range(99) >= 28)) begin
        in_valid <= 1;
        in_data <= pending_reqs.pop_front();
      end else begin
        in_valid <= 0;
      end
    end
    out_stall <= !no_idle && ($urandom_range(99) < 28);
  end

  // Monitor: predicts on accepted requests, checks accepted results
  always @(posedge clk) begin
    mrc_out_t exp_r;
    if (rst_n) begin
      if (in_valid && !in_stall) expected_results.push_back(core_result(in_data));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.pc_after !== out_data.pc_after) begin
            $error("pc_after exp %0d got %0d", exp_r.pc_after, out_data.pc_after);
            error_count++;
          end
          if (exp_r.reg_written !== out_data.reg_written) begin
            $error("reg_written exp %0d got %0d", exp_r.reg_written, out_data.reg_written);
            error_count++;
          end
          if (exp_r.reg_dest !== out_data.reg_dest) begin
            $error("reg_dest exp %0d got %0d", exp_r.reg_dest, out_data.reg_dest);
            error_count++;
          end
          if (exp_r.reg_value !== out_data.reg_value) begin
            $error("reg_value exp %h got %h", exp_r.reg_value, out_data.reg_value);
            error_count++;
          end
          if (exp_r.mem_written !== out_data.mem_written) begin
            $error("mem_written exp %0d got %0d", exp_r.mem_written, out_data.mem_written);
            error_count++;
          end
          if (exp_r.mem_word_index !== out_data.mem_word_index) begin
            $error("mem_word_index exp %0d got %0d", exp_r.mem_word_index,
                   out_data.mem_word_index);
            error_count++;
          end
          if (exp_r.mem_value !== out_data.mem_value) begin
            $error("mem_value exp %h got %h", exp_r.mem_value, out_data.mem_value);
            error_count++;
          end
          if (exp_r.branch_taken !== out_data.branch_taken) begin
            $error("branch_taken exp %0d got %0d", exp_r.branch_taken, out_data.branch_taken);
            error_count++;
          end
          if (exp_r.unknown_instr !== out_data.unknown_instr) begin
            $error("unknown_instr exp %0d got %0d", exp_r.unknown_instr,
                   out_data.unknown_instr);
            error_count++;
          end
          if (exp_r.read_value !== out_data.read_value) begin
            $error("read_value exp %h got %h", exp_r.read_value, out_data.read_value);
            error_count++;
          end
        end
      end
    end
  end

  function automatic mrc_in_t mk_req(logic [1:0] op, logic [6:0] la, logic [31:0] lw,
                                     logic [4:0] ri);
    mrc_in_t q;
    q.op = op; q.load_address = la; q.load_word = lw; q.read_index = ri;
    return q;
  endfunction

  function automatic logic [31:0] rand_instr();
    logic [5:0] opcs [11];
    logic [5:0] fns [4];
    logic [31:0] w;
    opcs = '{OPC_RTYPE, OPC_RTYPE, OPC_RTYPE, OPC_SUBI, OPC_SUBI, OPC_LW, OPC_SW,
             OPC_BGE, OPC_J, OPC_JAL, 6'd0};
    fns = '{FN_ADD, FN_OR, FN_SLT, FN_XOR};
    w = $urandom;
    if ($urandom_range(19) != 0) begin
      w[31:26] = opcs[$urandom_range(10)];
      if (w[31:26] == 6'd0) w[31:26] = 6'($urandom);
      if (w[31:26] == OPC_RTYPE && $urandom_range(9) != 0) w[5:0] = fns[$urandom_range(3)];
      // keep most branch offsets and jumps short so programs stay dense
      if (w[31:26] inside {OPC_BGE, OPC_J, OPC_JAL} && $urandom_range(3) != 0)
        w[15:7] = {9{w[6]}};
      if (w[31:26] inside {OPC_J, OPC_JAL} && $urandom_range(3) != 0)
        w[25:16] = {10{w[15]}};
    end
    return w;
  endfunction

  // Stimulus
  initial begin
    rst_n = 0; in_valid = 0; out_stall = 0; in_data = '0;
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    foreach (shadow_imem[i]) shadow_imem[i] = '0;
    foreach (shadow_dmem[i]) shadow_dmem[i] = '0;
    shadow_pc = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // Directed: every instruction, extremes, unknown codes and the unused op
    pending_reqs.push_back(mk_req(OP_EXEC, 0, 0, 0));
    pending_reqs.push_back(mk_req(OP_LOAD, 7'd1, {OPC_SUBI, 5'd0, 5'd1, 16'h8000}, 0));
    pending_reqs.push_back(mk_req(OP_LOAD, 7'd2, {OPC_SUBI, 5'd0, 5'd2, 16'h0001}, 0));
    pending_reqs.push_back(mk_req(OP_LOAD, 7'd3, {OPC_RTYPE, 5'd1, 5'd2, 5'd3, 5'd0, FN_ADD},
                                  0));
    pending_reqs.push_back(mk_req(OP_LOAD, 7'd4, {OPC_RTYPE, 5'd1, 5'd2, 5'd4, 5'd0, FN_SLT},
                                  0));
    pending_reqs.push_back(mk_req(OP_LOAD, 7'd5, {OPC_RTYPE, 5'd1, 5'd2, 5'd5, 5'd0, FN_XOR},
                                  0));
    pending_reqs.push_back(mk_req(OP_LOAD, 7'd6, {OPC_RTYPE, 5'd1, 5'd2, 5'd6, 5'd0, FN_OR},
                                  0));
    pending_reqs.push_back(mk_req(OP_LOAD, 7'd7, {OPC_SW, 5'd2, 5'd1, 16'hFFFC}, 0));
    pending_reqs.push_back(mk_req(OP_LOAD, 7'd8, {OPC_LW, 5'd2, 5'd7, 16'hFFFC}, 0));
    pending_reqs.push_back(mk_req(OP_LOAD, 7'd9, {OPC_BGE, 5'd1, 5'd2, 16'h0001}, 0));
    pending_reqs.push_back(mk_req(OP_LOAD, 7'd10, {OPC_BGE, 5'd2, 5'd1, 16'hFFFF}, 0));
    pending_reqs.push_back(mk_req(OP_LOAD, 7'd11, {OPC_RTYPE, 20'hFFFFF, 6'h3F}, 0));
    pending_reqs.push_back(mk_req(OP_LOAD, 7'd12, {6'h3F, 26'h3FFFFFF}, 0));
    pending_reqs.push_back(mk_req(OP_LOAD, 7'd13, {OPC_JAL, 26'h3FFFFFF}, 0));
    pending_reqs.push_back(mk_req(OP_LOAD, 7'd127, {OPC_J, 26'h2000000}, 0));
    for (int i = 0; i < 14; i++) pending_reqs.push_back(mk_req(OP_EXEC, 0, 0, 0));
    pending_reqs.push_back(mk_req(OP_NONE, 7'h7F, 32'hFFFFFFFF, 5'h1F));
    pending_reqs.push_back(mk_req(OP_READ, 0, 0, 5'd31));
    pending_reqs.push_back(mk_req(OP_READ, 0, 0, 5'd1));

    // Pause until the directed part has fully drained
    wait (pending_reqs.size() == 0);
    hold_send = 1;
    wait (expected_results.size() == 0 && !in_valid);
    @(negedge clk);
    hold_send = 0;

    // Random: a mix of program loads, execution requests, reads and noise
    for (int n = 0; n < 1200; ) begin
      int k;
      k = $urandom_range(99);
      if (n == 500) no_idle = 1;
      if (n == 700) no_idle = 0;
      if (k < 30) begin
        pending_reqs.push_back(mk_req(OP_LOAD, 7'($urandom), rand_instr(), 5'($urandom)));
      end else if (k < 85) begin
        pending_reqs.push_back(mk_req(OP_EXEC, 7'($urandom), $urandom, 5'($urandom)));
      end else if (k < 97) begin
        pending_reqs.push_back(mk_req(OP_READ, 7'($urandom), $urandom, 5'($urandom)));
      end else begin
        pending_reqs.push_back(mk_req(OP_NONE, 7'($urandom), $urandom, 5'($urandom)));
      end
      n++;
      if (pending_reqs.size() > 8) wait (pending_reqs.size() <= 4);
    end
    wait (pending_reqs.size() == 0);
    stim_done = 1;
  end

  // End of run
  initial begin
    wait (stim_done);
    wait (expected_results.size() == 0 && !(in_valid));
    repeat (50) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Timeout
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### mini_risc_core_step.f
rtl/mrc_pkg.sv
rtl/mrc_ram.sv
rtl/mrc_mod.sv
rtl/mrc_front.sv
rtl/mrc_back.sv
rtl/mini_risc_core_step.sv
dv/tb_mini_risc_core_step.sv
